/* sv/sstf_pkg.sv */
// Shared types and constants for the SSTF disk request scheduler.
package sstf_pkg;

    localparam int unsigned FieldBits = 16;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SCAN,
        S_TAIL,
        S_PICK
    } t_state;

    typedef struct packed {
        logic [FieldBits-1:0] request_tag;
        logic [FieldBits-1:0] arrival_stamp;
        logic [FieldBits-1:0] target_cylinder;
        logic [FieldBits-1:0] owner_process;
        logic                 batch_end;
    } t_req;

    typedef struct packed {
        logic [FieldBits-1:0] served_tag;
        logic [FieldBits-1:0] served_stamp;
        logic [FieldBits-1:0] served_cylinder;
        logic [FieldBits-1:0] served_process;
        logic                 final_result;
    } t_rsp;

endpackage

/* sv/sstf_if.sv */
// Valid/ready channel interfaces for request and result items.
interface sstf_req_if;
    logic            valid;
    logic            ready;
    sstf_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sstf_rsp_if;
    logic            valid;
    logic            ready;
    sstf_pkg::t_rsp  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/sstf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sstf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/sstf_disk_request_scheduler.sv */
// SSTF disk request scheduler: loads a batch, then emits it in nearest-cylinder order.
// Loading accepts one item per cycle in S_LOAD; an item without batch_end gives no result.
// Each result needs a scan of all n loaded entries through the store's read port,
// then S_TAIL and S_PICK; a batch of n gives n results, and S_PICK waits on a held result.
// Synchronous active-low reset clears state, load count, served flags, head and start
// register; the request store is not cleared and holds entries only once written.
module sstf_disk_request_scheduler #(
    parameter int unsigned MAX_REQUESTS = 32,
    parameter int unsigned CYL_BITS     = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [sstf_pkg::FieldBits-1:0] i_cfg_wr_data,
    sstf_req_if.sink                      i_req,
    sstf_rsp_if.source                    o_rsp
);

    localparam int unsigned FB  = sstf_pkg::FieldBits;
    localparam int unsigned CW  = (CYL_BITS < FB) ? CYL_BITS : FB;
    localparam int unsigned EW  = 3 * FB + CW;
    localparam int unsigned AW  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int unsigned NW  = $clog2(MAX_REQUESTS + 1);
    localparam logic [NW-1:0] MaxCount = NW'(MAX_REQUESTS);

    sstf_pkg::t_state r_state, n_state;

    logic [NW-1:0]           r_count;
    logic [NW-1:0]           r_served;
    logic [NW-1:0]           r_scan_idx;
    logic [MAX_REQUESTS-1:0] r_flags;
    logic [CW-1:0]           r_head;
    logic [FB-1:0]           r_start_head;
    logic                    r_cmp_valid;
    logic [AW-1:0]           r_cmp_idx;
    logic                    r_found;
    logic [AW-1:0]           r_best_idx;
    logic [CW-1:0]           r_best_d;
    logic [EW-1:0]           r_best_entry;
    logic                    r_out_valid;
    sstf_pkg::t_rsp          r_out;

    logic          w_accept;
    logic          w_store;
    logic          w_rd_en;
    logic          w_pick;
    logic          w_final;
    logic          w_better;
    logic [EW-1:0] w_rd_data;
    logic [EW-1:0] w_wr_data;
    logic [CW-1:0] w_rd_cyl;
    logic [FB-1:0] w_rd_stamp;
    logic [FB-1:0] w_best_stamp;
    logic [CW-1:0] w_dist;

    assign w_accept = i_req.valid && i_req.ready;
    assign w_store  = w_accept && (r_count < MaxCount);
    assign w_final  = (r_served + NW'(1)) == r_count;

    assign w_wr_data = {i_req.data.request_tag, i_req.data.arrival_stamp,
                        i_req.data.target_cylinder[CW-1:0], i_req.data.owner_process};

    sstf_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_REQUESTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_store),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_scan_idx[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_cyl     = w_rd_data[FB +: CW];
    assign w_rd_stamp   = w_rd_data[FB + CW +: FB];
    assign w_best_stamp = r_best_entry[FB + CW +: FB];

    always_comb begin
        w_dist   = (w_rd_cyl >= r_head) ? (w_rd_cyl - r_head) : (r_head - w_rd_cyl);
        w_better = r_cmp_valid && !r_flags[r_cmp_idx] &&
                   (!r_found || (w_dist < r_best_d) ||
                    ((w_dist == r_best_d) && (w_rd_stamp < w_best_stamp)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sstf_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        w_rd_en     = 1'b0;
        w_pick      = 1'b0;
        unique case (r_state)
            sstf_pkg::S_LOAD: begin
                i_req.ready = 1'b1;
                if (w_accept && i_req.data.batch_end) begin
                    n_state = sstf_pkg::S_SCAN;
                end
            end
            sstf_pkg::S_SCAN: begin
                w_rd_en = 1'b1;
                if ((r_scan_idx + NW'(1)) == r_count) begin
                    n_state = sstf_pkg::S_TAIL;
                end
            end
            sstf_pkg::S_TAIL: begin
                n_state = sstf_pkg::S_PICK;
            end
            sstf_pkg::S_PICK: begin
                if (!r_out_valid || o_rsp.ready) begin
                    w_pick  = 1'b1;
                    n_state = w_final ? sstf_pkg::S_LOAD : sstf_pkg::S_SCAN;
                end
            end
            default: n_state = sstf_pkg::S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_served     <= '0;
            r_scan_idx   <= '0;
            r_flags      <= '0;
            r_head       <= '0;
            r_start_head <= '0;
            r_cmp_valid  <= 1'b0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_start_head <= i_cfg_wr_data;
            end

            if (w_store) begin
                r_count <= r_count + NW'(1);
            end
            if (w_accept && i_req.data.batch_end) begin
                r_head     <= r_start_head[CW-1:0];
                r_flags    <= '0;
                r_served   <= '0;
                r_scan_idx <= '0;
                r_found    <= 1'b0;
            end

            r_cmp_valid <= w_rd_en;
            r_cmp_idx   <= r_scan_idx[AW-1:0];
            if (w_rd_en) begin
                r_scan_idx <= r_scan_idx + NW'(1);
            end

            if (w_better) begin
                r_found      <= 1'b1;
                r_best_idx   <= r_cmp_idx;
                r_best_d     <= w_dist;
                r_best_entry <= w_rd_data;
            end

            if (w_pick) begin
                r_out_valid          <= 1'b1;
                r_out.served_tag      <= r_best_entry[2 * FB + CW +: FB];
                r_out.served_stamp    <= r_best_entry[FB + CW +: FB];
                r_out.served_cylinder <= FB'(r_best_entry[FB +: CW]);
                r_out.served_process  <= r_best_entry[FB-1:0];
                r_out.final_result    <= w_final;
                r_flags[r_best_idx]   <= 1'b1;
                r_head                <= r_best_entry[FB +: CW];
                r_served              <= r_served + NW'(1);
                r_scan_idx            <= '0;
                r_found               <= 1'b0;
                if (w_final) begin
                    r_count <= '0;
                end
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MaxCount)
        else $error("load count beyond store depth");

    a_pick_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sstf_pkg::S_PICK) |-> r_found)
        else $error("pick without a candidate");

    a_pick_unserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sstf_pkg::S_PICK) |-> !r_flags[r_best_idx])
        else $error("picked entry already served");

    a_served_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != sstf_pkg::S_LOAD) |-> (r_served < r_count))
        else $error("served count reached load count while scheduling");

    a_batch_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.data.batch_end) |=> (r_state == sstf_pkg::S_SCAN))
        else $error("batch end did not start a scan");

endmodule

/* test/tb_sstf_disk_request_scheduler.sv */
// Testbench for the SSTF disk request scheduler: directed plan, random batches, self-check.
module tb_sstf_disk_request_scheduler;

    localparam int MaxRequests  = 32;
    localparam int RandomItems  = 420;
    localparam int SettleCycles = 40;
    localparam int QuietLimit   = 2000;
    localparam int DirRows      = 16;

    typedef struct {
        bit                             set_start;
        logic [sstf_pkg::FieldBits-1:0] start_val;
        sstf_pkg::t_req                 item;
        bit                             known;
        sstf_pkg::t_rsp                 known_rsp;
    } t_plan_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [sstf_pkg::FieldBits-1:0] i_cfg_wr_data;

    sstf_req_if req_ch ();
    sstf_rsp_if rsp_ch ();

    sstf_disk_request_scheduler #(
        .MAX_REQUESTS (MaxRequests),
        .CYL_BITS     (16)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req_ch),
        .o_rsp         (rsp_ch)
    );

    // scheduler shadow state
    sstf_pkg::t_req                 load_buf [MaxRequests];
    int                             load_cnt = 0;
    logic [sstf_pkg::FieldBits-1:0] start_cyl = '0;

    sstf_pkg::t_rsp served_q [$];
    int             fault_cnt = 0;
    int             quiet_cycles = 0;
    bit             src_idle = 1'b1;
    bit             known_pending = 1'b0;
    sstf_pkg::t_rsp known_rsp = '0;

    t_plan_row dir_plan [DirRows] = '{
        '{1'b0, 16'h0000, '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b1},
          1'b1, '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b1}},
        '{1'b0, 16'h0000, '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1},
          1'b1, '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1}},
        // equal seek distances: stamp first, then load order
        '{1'b1, 16'h8000, '{16'h0001, 16'h0005, 16'h7FFF, 16'h0011, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0000, '{16'h0002, 16'h0003, 16'h8001, 16'h0012, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0000, '{16'h0003, 16'h0003, 16'h8001, 16'h0013, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0000, '{16'h0004, 16'h0000, 16'h0000, 16'h0014, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0000, '{16'h0005, 16'hFFFF, 16'hFFFF, 16'h0015, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0000, '{16'h0006, 16'h0003, 16'h7FFF, 16'h0016, 1'b1}, 1'b0, '0},
        '{1'b1, 16'hFFFF, '{16'h00AA, 16'h1234, 16'h0000, 16'h5678, 1'b1},
          1'b1, '{16'h00AA, 16'h1234, 16'h0000, 16'h5678, 1'b1}},
        '{1'b1, 16'h0000, '{16'h0010, 16'h0007, 16'hFFFF, 16'h0020, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0000, '{16'h0011, 16'h0007, 16'h0000, 16'h0021, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0000, '{16'h0012, 16'h0007, 16'hFFFF, 16'h0022, 1'b1}, 1'b0, '0},
        '{1'b1, 16'h1234, '{16'h0021, 16'h0010, 16'h1200, 16'h0031, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0000, '{16'h0022, 16'h0011, 16'h1300, 16'h0032, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0000, '{16'h0023, 16'h0012, 16'h1000, 16'h0033, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0000, '{16'h0024, 16'h0013, 16'h2000, 16'h0034, 1'b1}, 1'b0, '0}
    };

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void sstf_schedule(input sstf_pkg::t_req r,
                                          ref sstf_pkg::t_rsp picks[$]);
        logic [31:0]                    taken;
        logic [sstf_pkg::FieldBits-1:0] head;
        logic [sstf_pkg::FieldBits-1:0] gap_i;
        logic [sstf_pkg::FieldBits-1:0] best_gap;
        int                             best;
        int                             n;
        sstf_pkg::t_rsp                 pick;
        if (load_cnt < MaxRequests) begin
            load_buf[load_cnt] = r;
            load_cnt++;
        end
        if (!r.batch_end) return;
        n = load_cnt;
        head = start_cyl;
        taken = '0;
        for (int k = 0; k < n; k++) begin
            best = -1;
            best_gap = '0;
            for (int i = 0; i < n; i++) begin
                if (taken[i]) continue;
                gap_i = (load_buf[i].target_cylinder > head) ?
                        load_buf[i].target_cylinder - head : head - load_buf[i].target_cylinder;
                if (best < 0 || gap_i < best_gap || (gap_i == best_gap &&
                        load_buf[i].arrival_stamp < load_buf[best].arrival_stamp)) begin
                    best = i;
                    best_gap = gap_i;
                end
            end
            taken[best] = 1'b1;
            head = load_buf[best].target_cylinder;
            pick.served_tag      = load_buf[best].request_tag;
            pick.served_stamp    = load_buf[best].arrival_stamp;
            pick.served_cylinder = load_buf[best].target_cylinder;
            pick.served_process  = load_buf[best].owner_process;
            pick.final_result    = (k == n - 1);
            picks.push_back(pick);
        end
        load_cnt = 0;
    endfunction

    function automatic void check_field(input string name,
                                        input logic [sstf_pkg::FieldBits-1:0] want,
                                        input logic [sstf_pkg::FieldBits-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fault_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin : track_requests
        sstf_pkg::t_rsp picks [$];
        picks.delete();
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            sstf_schedule(req_ch.data, picks);
            if (known_pending && req_ch.data.batch_end) begin
                served_q.push_back(known_rsp);
            end else begin
                foreach (picks[k]) served_q.push_back(picks[k]);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        sstf_pkg::t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (served_q.size() == 0) begin
                $error("unexpected item: served_tag %h", rsp_ch.data.served_tag);
                fault_cnt++;
            end else begin
                want = served_q.pop_front();
                check_field("served_tag", want.served_tag, rsp_ch.data.served_tag);
                check_field("served_stamp", want.served_stamp, rsp_ch.data.served_stamp);
                check_field("served_cylinder", want.served_cylinder, rsp_ch.data.served_cylinder);
                check_field("served_process", want.served_process, rsp_ch.data.served_process);
                check_field("final_result", {15'b0, want.final_result},
                            {15'b0, rsp_ch.data.final_result});
            end
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= QuietLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else if (!i_rst_n || (req_ch.valid && req_ch.ready) ||
                     (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : result_sink
        int stall;
        int run_left;
        bit busy;
        rsp_ch.ready = 1'b0;
        run_left = 0;
        busy = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (run_left == 0) begin
                busy = $urandom_range(0, 1);
                run_left = $urandom_range(5, 25);
            end
            run_left--;
            stall = busy ? $urandom_range(0, 10) : 0;
            if (stall != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            @(negedge i_clk);
        end
    end

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (served_q.size() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic set_start_cyl(input logic [sstf_pkg::FieldBits-1:0] v);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        start_cyl = v;
    endtask

    task automatic send_item(input sstf_pkg::t_req r, input bit is_known,
                             input sstf_pkg::t_rsp kr);
        int gap;
        gap = src_idle ? $urandom_range(0, 10) : 0;
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.data   <= r;
        req_ch.valid  <= 1'b1;
        known_pending <= is_known;
        known_rsp     <= kr;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        sstf_pkg::t_req item;
        int             batch_len;
        int             loaded;
        bit             narrow;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        req_ch.valid  = 1'b0;
        req_ch.data   = '0;
        loaded        = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_plan[r]) begin
            if (dir_plan[r].set_start) set_start_cyl(dir_plan[r].start_val);
            send_item(dir_plan[r].item, dir_plan[r].known, dir_plan[r].known_rsp);
        end

        while (loaded < RandomItems) begin
            batch_len = ($urandom_range(0, 6) == 0) ? $urandom_range(28, 35)
                                                    : $urandom_range(1, 8);
            narrow = $urandom_range(0, 1);
            case ($urandom_range(0, 7))
                0: set_start_cyl(16'h0000);
                1: set_start_cyl(16'hFFFF);
                2: set_start_cyl(16'($urandom));
                3: drain_results();
                default: ;
            endcase
            src_idle = $urandom_range(0, 2) != 0;
            for (int j = 0; j < batch_len; j++) begin
                item.request_tag   = 16'($urandom);
                item.owner_process = 16'($urandom);
                if (narrow) begin
                    item.arrival_stamp   = 16'($urandom_range(0, 3));
                    item.target_cylinder = $urandom_range(0, 1) ?
                                           16'($urandom_range(0, 15)) :
                                           16'($urandom_range(65520, 65535));
                end else begin
                    item.arrival_stamp   = 16'($urandom);
                    item.target_cylinder = 16'($urandom);
                end
                item.batch_end = (j == batch_len - 1);
                send_item(item, 1'b0, '0);
                if (j < MaxRequests) loaded++;
            end
        end

        drain_results();
        if (fault_cnt == 0 && served_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* sstf_disk_request_scheduler.f */
sv/sstf_pkg.sv
sv/sstf_if.sv
sv/sstf_ram.sv
sv/sstf_disk_request_scheduler.sv
test/tb_sstf_disk_request_scheduler.sv
